@@ design/sspio_pkg.sv @@
// ----------------------------------------------------------------------------
// sspio_pkg
// types and port codes shared by the sound/shift port i/o unit
// ----------------------------------------------------------------------------
`default_nettype none

package sspio_pkg;

  localparam int unsigned ByteW   = 8;
  localparam int unsigned AmountW = 3;
  localparam int unsigned InDataW = 4 * ByteW;
  localparam int unsigned OutDataW = 2 * ByteW;

  // access kinds
  localparam logic FUNC_READ  = 1'b0;
  localparam logic FUNC_WRITE = 1'b1;

  // port numbers
  localparam logic [ByteW-1:0] PORT_BUTTONS_ONE = 8'd1;
  localparam logic [ByteW-1:0] PORT_BUTTONS_TWO = 8'd2;
  localparam logic [ByteW-1:0] PORT_SHIFT_READ  = 8'd3;
  localparam logic [ByteW-1:0] PORT_SHIFT_AMT   = 8'd2;
  localparam logic [ByteW-1:0] PORT_SOUND_A     = 8'd3;
  localparam logic [ByteW-1:0] PORT_SHIFT_DATA  = 8'd4;
  localparam logic [ByteW-1:0] PORT_SOUND_B     = 8'd5;

  typedef struct packed {
    logic             func;
    logic [ByteW-1:0] port_number;
    logic [ByteW-1:0] write_data;
    logic [ByteW-1:0] player_one_buttons;
    logic [ByteW-1:0] player_two_buttons;
  } item_t;

  typedef struct packed {
    logic [ByteW-1:0] read_data;
    logic [ByteW-1:0] sound_start;
  } result_t;

endpackage

`default_nettype wire

@@ design/sspio_in_stage.sv @@
// ----------------------------------------------------------------------------
// sspio_in_stage
// input register for one port access beat
// ----------------------------------------------------------------------------
`default_nettype none

module sspio_in_stage
  import sspio_pkg::*;
(
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 s_tvalid,
  output logic                s_tready,
  input  wire  [InDataW-1:0]  s_tdata,
  input  wire                 s_tuser,
  input  wire                 advance,
  output logic                in_vld,
  output item_t               item
);

  assign s_tready = !in_vld || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_vld <= 1'b0;
    end else if (s_tready) begin
      in_vld <= s_tvalid;
    end
  end

  // payload, lowest field first in tdata
  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      item.func               <= s_tuser;
      item.port_number        <= s_tdata[ByteW-1:0];
      item.write_data         <= s_tdata[2*ByteW-1:ByteW];
      item.player_one_buttons <= s_tdata[3*ByteW-1:2*ByteW];
      item.player_two_buttons <= s_tdata[4*ByteW-1:3*ByteW];
    end
  end

endmodule

`default_nettype wire

@@ design/sspio_exec.sv @@
// ----------------------------------------------------------------------------
// sspio_exec
// port state (shift register, amount, sound latches) and access decode
// ----------------------------------------------------------------------------
`default_nettype none

module sspio_exec
  import sspio_pkg::*;
(
  input  wire         clk,
  input  wire         rst,
  input  wire         advance,
  input  wire item_t  item,
  output result_t     result
);

  logic [ByteW-1:0]   shift_low_byte,  shift_low_byte_next;
  logic [ByteW-1:0]   shift_high_byte, shift_high_byte_next;
  logic [AmountW-1:0] shift_amount,    shift_amount_next;
  logic [ByteW-1:0]   sound_latch_a,   sound_latch_a_next;
  logic [ByteW-1:0]   sound_latch_b,   sound_latch_b_next;

  logic [2*ByteW-1:0] shift_word;
  logic [2*ByteW-1:0] shifted;
  logic [3:0]         shift_dist;
  logic [ByteW-1:0]   rise_a;
  logic [ByteW-1:0]   rise_b;

  assign shift_word = {shift_high_byte, shift_low_byte};
  assign shift_dist = 4'd8 - {1'b0, shift_amount};
  assign shifted    = shift_word >> shift_dist;
  assign rise_a     = item.write_data & ~sound_latch_a;
  assign rise_b     = item.write_data & ~sound_latch_b;

  always_comb begin
    result               = '0;
    shift_low_byte_next  = shift_low_byte;
    shift_high_byte_next = shift_high_byte;
    shift_amount_next    = shift_amount;
    sound_latch_a_next   = sound_latch_a;
    sound_latch_b_next   = sound_latch_b;
    if (item.func == FUNC_READ) begin
      unique case (item.port_number)
        PORT_BUTTONS_ONE: result.read_data = item.player_one_buttons;
        PORT_BUTTONS_TWO: result.read_data = item.player_two_buttons;
        PORT_SHIFT_READ:  result.read_data = shifted[ByteW-1:0];
        default:          result.read_data = '0;
      endcase
    end else begin
      unique case (item.port_number)
        PORT_SHIFT_AMT: begin
          shift_amount_next = item.write_data[AmountW-1:0];
        end
        PORT_SOUND_A: begin
          sound_latch_a_next = item.write_data;
          result.sound_start = {5'd0, rise_a[3:1]};
        end
        PORT_SHIFT_DATA: begin
          shift_low_byte_next  = shift_high_byte;
          shift_high_byte_next = item.write_data;
        end
        PORT_SOUND_B: begin
          sound_latch_b_next = item.write_data;
          result.sound_start = {rise_b[4:0], 3'd0};
        end
        default: begin
          result.sound_start = '0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      shift_low_byte  <= '0;
      shift_high_byte <= '0;
      shift_amount    <= '0;
      sound_latch_a   <= '0;
      sound_latch_b   <= '0;
    end else if (advance) begin
      shift_low_byte  <= shift_low_byte_next;
      shift_high_byte <= shift_high_byte_next;
      shift_amount    <= shift_amount_next;
      sound_latch_a   <= sound_latch_a_next;
      sound_latch_b   <= sound_latch_b_next;
    end
  end

endmodule

`default_nettype wire

@@ design/shift_register_sound_port_io_unit.sv @@
// ----------------------------------------------------------------------------
// shift_register_sound_port_io_unit
// i/o port block: button ports, 16-bit shift register and sound latches
// ----------------------------------------------------------------------------
// path: an accepted input beat passes the input register, then the result register, to its result beat on m_*
// throughput: one access per cycle while m_tready stays high, set by the single pass through the
//   decode and shifter between the input register and the result register
// reset: rst (synchronous) empties both stages and clears the shift
//   register, shift amount and both sound latches
// ----------------------------------------------------------------------------
`default_nettype none

module shift_register_sound_port_io_unit
  import sspio_pkg::*;
(
  input  wire                  clk,
  input  wire                  rst,
  // access beats
  input  wire                  s_tvalid,
  output logic                 s_tready,
  // s_tdata, low bit up: port_number[7:0], write_data[7:0],
  //   player_one_buttons[7:0], player_two_buttons[7:0]
  input  wire  [InDataW-1:0]   s_tdata,
  // s_tuser: func (0 read, 1 write)
  input  wire                  s_tuser,
  // result beats
  output logic                 m_tvalid,
  input  wire                  m_tready,
  // m_tdata, low bit up: read_data[7:0], sound_start[7:0]
  output logic [OutDataW-1:0]  m_tdata
);

  logic    in_vld;
  logic    advance;
  item_t   item;
  result_t result;

  // the input stage moves on whenever the result register is free or
  // is being emptied in the same cycle
  assign advance = in_vld && (!m_tvalid || m_tready);

  sspio_in_stage u_in_stage (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .advance  (advance),
    .in_vld   (in_vld),
    .item     (item)
  );

  // state updates on the same edge that loads the result register
  sspio_exec u_exec (
    .clk     (clk),
    .rst     (rst),
    .advance (advance),
    .item    (item),
    .result  (result)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (!m_tvalid || m_tready) begin
      m_tvalid <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      m_tdata <= {result.sound_start, result.read_data};
    end
  end

  // a stalled result never lets the input stage run over it
  a_no_overrun : assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |-> !advance)
    else $error("input stage advanced over a stalled result");

  // reads never report a sound start
  a_read_no_sound : assert property (@(posedge clk) disable iff (rst)
    advance && (item.func == FUNC_READ) |=> m_tdata[OutDataW-1:ByteW] == '0)
    else $error("sound start flagged on a read");

  // writes always return zero read data
  a_write_zero_read : assert property (@(posedge clk) disable iff (rst)
    advance && (item.func == FUNC_WRITE) |=> m_tdata[ByteW-1:0] == '0)
    else $error("nonzero read data on a write");

  // an accepted beat lands in the input stage
  a_accept_loads : assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> in_vld)
    else $error("accepted beat lost at input stage");

endmodule

`default_nettype wire
